// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, suppressed while reset is high.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

// ===== sv/dgls_pkg.sv =====
// ----------------------------------------------------------------------------
// dgls_pkg
// Shared constants and command type for the diagonal Gaussian log scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package dgls_pkg;

   localparam int MAX_DIM = 64;
   localparam int ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   localparam logic [1:0] MODE_LOAD_MEAN = 2'd0;
   localparam logic [1:0] MODE_LOAD_IVAR = 2'd1;
   localparam logic [1:0] MODE_SCORE     = 2'd2;

   localparam int SAMPLE_W = 16;
   localparam int DIFF_W   = 17;
   localparam int SQ_W     = 32;
   localparam int TERM_W   = 48;
   localparam int SUM_W    = 56;
   localparam int HALF_W   = 44;
   localparam int SCORE_W  = 32;

   // Controller to datapath commands
   typedef struct packed {
      logic wr_mean;   // load beat: write mean store
      logic wr_ivar;   // load beat: write inverse variance store
      logic capture;   // score beat: latch sample
      logic square;    // diff and square
      logic mult;      // times inverse variance
      logic accum;     // saturating add, advance counter
      logic finish;    // form score, clear sum and counter
   } dgls_cmd_type;

endpackage

`default_nettype wire

// ===== sv/dgls_ram.sv =====
// ----------------------------------------------------------------------------
// dgls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dgls_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/dgls_ctrl.sv =====
// ----------------------------------------------------------------------------
// dgls_ctrl
// Sequencer: decodes input beats, steps a score beat through the datapath,
// owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dgls_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_mode,
   input  wire logic                  req_last,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output dgls_pkg::dgls_cmd_type     cmd
);
   import dgls_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SQUARE = 3'd1;
   localparam logic [2:0] S_MULT   = 3'd2;
   localparam logic [2:0] S_ACCUM  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       last_ff, last_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.wr_mean = (req_mode == MODE_LOAD_MEAN);
               cmd.wr_ivar = (req_mode == MODE_LOAD_IVAR);
               if (req_mode == MODE_SCORE) begin
                  cmd.capture = 1'b1;
                  last_in     = req_last;
                  state_in    = S_SQUARE;
               end
            end
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_MULT;
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = last_ff ? S_FINISH : S_IDLE;
         end
         S_FINISH: begin
            // wait here until the output register can take the score
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_AT(a_finish_needs_room, clock, reset, cmd.finish |-> out_free)
   `ASSERT_AT(a_last_goes_finish, clock, reset, (state_ff == S_ACCUM && last_ff) |=> (state_ff == S_FINISH))

endmodule

`default_nettype wire

// ===== sv/dgls_datapath.sv =====
// ----------------------------------------------------------------------------
// dgls_datapath
// Mean and inverse variance stores, square / multiply / accumulate pipe,
// final rounding, subtraction and clamp, output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dgls_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire dgls_pkg::dgls_cmd_type         cmd,
   input  wire logic [5:0]                     req_element_index,
   input  wire logic signed [15:0]             req_sample,
   input  wire logic [15:0]                    req_inv_variance,
   input  wire logic                           csr_wr_en,
   input  wire logic signed [31:0]             csr_wr_data,
   output logic signed [31:0]                  rsp_score,
   output logic                                rsp_saturated
);
   import dgls_pkg::*;

   logic                     in_range;
   logic [ADDR_W-1:0]        wr_addr;
   logic [SAMPLE_W-1:0]      mean_rd;
   logic [SAMPLE_W-1:0]      ivar_rd;

   logic signed [31:0]       log_const_ff;
   logic [SAMPLE_W-1:0]      sample_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic [SAMPLE_W-1:0]      ivar_ff;
   logic [TERM_W-1:0]        term_ff;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [ADDR_W-1:0]        count_ff, count_in;
   logic signed [31:0]       score_ff, score_in;
   logic                     sat_ff, sat_in;

   logic signed [DIFF_W-1:0]   diff;
   logic signed [2*DIFF_W-1:0] diff_sq;
   logic [SUM_W:0]             sum_wide;
   logic [SUM_W:0]             sum_round;
   logic [HALF_W-1:0]          half;
   logic signed [HALF_W+1:0]   result;
   logic                       fits;

   assign in_range = (32'(req_element_index) < MAX_DIM);
   assign wr_addr  = ADDR_W'(req_element_index);

   dgls_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_DIM), .AW(ADDR_W)) u_mean_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_mean && in_range),
      .wr_addr (wr_addr),
      .wr_data (req_sample),
      .rd_addr (count_ff),
      .rd_data (mean_rd)
   );

   dgls_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_DIM), .AW(ADDR_W)) u_ivar_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_ivar && in_range),
      .wr_addr (wr_addr),
      .wr_data (req_inv_variance),
      .rd_addr (count_ff),
      .rd_data (ivar_rd)
   );

   // diff is exact in 17 bits; its square fits in 32
   assign diff    = $signed({sample_ff[SAMPLE_W-1], sample_ff})
                  - $signed({mean_rd[SAMPLE_W-1], mean_rd});
   assign diff_sq = diff * diff;

   // saturating accumulate
   assign sum_wide = {1'b0, sum_ff} + {{(SUM_W-TERM_W+1){1'b0}}, term_ff};

   // round half sum to Q16.16, subtract, clamp
   assign sum_round = {1'b0, sum_ff} + (SUM_W+1)'(4096);
   assign half      = sum_round[SUM_W:13];
   assign result    = $signed({{(HALF_W-30){log_const_ff[31]}}, log_const_ff})
                    - $signed({2'b00, half});
   assign fits      = (&result[HALF_W+1:31]) || !(|result[HALF_W+1:31]);

   always_comb begin
      if (fits) begin
         score_in = result[31:0];
         sat_in   = 1'b0;
      end else if (result[HALF_W+1]) begin
         score_in = 32'sh8000_0000;
         sat_in   = 1'b1;
      end else begin
         score_in = 32'sh7FFF_FFFF;
         sat_in   = 1'b1;
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (cmd.finish) begin
         sum_in   = '0;
         count_in = '0;
      end else if (cmd.accum) begin
         sum_in   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
         count_in = (count_ff == ADDR_W'(MAX_DIM - 1)) ? '0 : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_const_ff <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            log_const_ff <= csr_wr_data;
         end
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample;
      end
      if (cmd.square) begin
         sq_ff   <= diff_sq[SQ_W-1:0];
         ivar_ff <= ivar_rd;
      end
      if (cmd.mult) begin
         term_ff <= sq_ff * ivar_ff;
      end
      if (cmd.finish) begin
         score_ff <= score_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_score     = score_ff;
   assign rsp_saturated = sat_ff;

   `ASSERT_AT(a_finish_clears, clock, reset, cmd.finish |=> (sum_ff == '0 && count_ff == '0))
   `ASSERT_AT(a_sum_monotone, clock, reset, cmd.accum |=> (sum_ff >= $past(sum_ff)))

endmodule

`default_nettype wire

// ===== sv/diagonal_gaussian_log_score.sv =====
// Load beats (mean / inverse variance writes, unused mode) complete in the accept cycle.
// A score beat steps through store read, diff and square, multiply, accumulate.
// A beat marked last adds a finish step that waits while the previous score is unread.
// The sequencer holds one score beat at a time; the output register frees the input side.
// Synchronous active-high reset clears sequencer state, log constant, sum, counter and result valid;
// the stores are not cleared and hold garbage until written.
// ----------------------------------------------------------------------------
// diagonal_gaussian_log_score
// Scores a streamed feature vector against one diagonal-covariance Gaussian:
// log_constant - 1/2 * sum((x - mean)^2 * inv_variance), clamped to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module diagonal_gaussian_log_score (
   input  wire logic               clock,
   input  wire logic               reset,
   // input beats
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_mode,
   input  wire logic [5:0]         req_element_index,
   input  wire logic signed [15:0] req_sample,
   input  wire logic [15:0]        req_inv_variance,
   input  wire logic               req_last,
   // result beats
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_score,
   output logic                    rsp_saturated,
   // log constant register, signed Q16.16
   input  wire logic               csr_wr_en,
   input  wire logic signed [31:0] csr_wr_data
);
   import dgls_pkg::*;

   dgls_cmd_type cmd;

   // Controller: accepts a beat only when idle. Load beats write the stores
   // in the accept cycle; a score beat is walked through the pipe one step
   // per cycle, and a last beat waits in the finish step if the previous
   // score is still unread.
   dgls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath: element counter addresses both stores; the 56-bit sum
   // saturates, and the half sum is rounded to nearest, ties upward.
   dgls_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_element_index (req_element_index),
      .req_sample        (req_sample),
      .req_inv_variance  (req_inv_variance),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_score         (rsp_score),
      .rsp_saturated     (rsp_saturated)
   );

endmodule

`default_nettype wire

// ===== verif/diagonal_gaussian_log_score_tb.sv =====
// ----------------------------------------------------------------------------
// diagonal_gaussian_log_score_tb
// Self-checking bench for the diagonal Gaussian log scorer. A short table of
// directed beats covers reset state, rounding, clipping and ignored fields.
// Random phases follow, with store loads, vectors of random length, stray
// loads and unused-mode beats. Every result beat is checked against an
// in-bench fixed-point predictor or, for typed rows, the table's score.
// ----------------------------------------------------------------------------
`default_nettype none

module diagonal_gaussian_log_score_tb;

   import dgls_pkg::*;

   // Mode 3 has no name in the package; the block drops such beats.
   localparam logic [1:0]  MODE_UNUSED   = 2'd3;
   localparam int          ITEMS_TARGET  = 1900;
   localparam int          PHASES        = 6;
   localparam int          LONG_HOLD     = 300;   // receiver hold-off, cycles
   localparam int          SETTLE_CYCLES = 12;    // settle wait after the last result
   localparam int          TIMEOUT_UNITS = 4_000_000;
   localparam logic [55:0] SUM_MAX       = '1;
   localparam longint      SCORE_MIN     = -(64'sd1 <<< 31);
   localparam longint      SCORE_MAX     = (64'sd1 <<< 31) - 1;

   // Phases with a fixed part ahead of their random body
   localparam int PH_PRELOAD      = 0;
   localparam int PH_BACKPRESSURE = 1;
   localparam int PH_OVERFLOW     = 2;
   localparam int PH_DRAIN        = 3;

   typedef struct {
      logic signed [31:0] score;
      logic               sat;
   } score_type;

   // Directed table: ROW_BEAT is checked by the predictor, ROW_TYPED carries
   // its expected score in value/sat, ROW_CSR writes value to the register.
   typedef enum logic [1:0] {ROW_BEAT, ROW_TYPED, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   mode;
      logic [5:0]   idx;
      logic [15:0]  smp;
      logic [15:0]  ivr;
      logic         is_last;
      logic [31:0]  value;
      logic         sat;
   } stim_row_type;

   localparam int N_DIRECTED = 23;
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      // straight out of reset: log constant 0, exact match scores 0
      '{ROW_BEAT,  MODE_LOAD_MEAN, 6'd0,  16'h0100, 16'h0000, 1'b0, 32'h0,        1'b0},
      '{ROW_BEAT,  MODE_LOAD_IVAR, 6'd0,  16'h0000, 16'h1000, 1'b0, 32'h0,        1'b0},
      '{ROW_TYPED, MODE_SCORE,     6'd0,  16'h0100, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
      // unused mode, every field high: dropped, no result
      '{ROW_BEAT,  MODE_UNUSED,    6'd63, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0,        1'b0},
      // top index; last on a load is ignored
      '{ROW_BEAT,  MODE_LOAD_MEAN, 6'd63, 16'h8000, 16'h0000, 1'b1, 32'h0,        1'b0},
      '{ROW_BEAT,  MODE_LOAD_IVAR, 6'd63, 16'h0000, 16'hFFFF, 1'b1, 32'h0,        1'b0},
      // widest diff times largest weight clips to the negative rail
      '{ROW_BEAT,  MODE_LOAD_MEAN, 6'd0,  16'h8000, 16'h0000, 1'b0, 32'h0,        1'b0},
      '{ROW_BEAT,  MODE_LOAD_IVAR, 6'd0,  16'h0000, 16'hFFFF, 1'b0, 32'h0,        1'b0},
      '{ROW_TYPED, MODE_SCORE,     6'd0,  16'h7FFF, 16'h0000, 1'b1, 32'h8000_0000, 1'b1},
      // half-sum rounding: sum 4096 is a tie and rounds up to 1
      '{ROW_BEAT,  MODE_LOAD_MEAN, 6'd0,  16'h0000, 16'h0000, 1'b0, 32'h0,        1'b0},
      '{ROW_BEAT,  MODE_LOAD_IVAR, 6'd0,  16'h0000, 16'h0001, 1'b0, 32'h0,        1'b0},
      '{ROW_TYPED, MODE_SCORE,     6'd0,  16'h0040, 16'h0000, 1'b1, 32'hFFFF_FFFF, 1'b0},
      // sum 4095 rounds down to 0
      '{ROW_BEAT,  MODE_LOAD_IVAR, 6'd0,  16'h0000, 16'h0FFF, 1'b0, 32'h0,        1'b0},
      '{ROW_TYPED, MODE_SCORE,     6'd0,  16'h0001, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
      // register extremes with zero distance pass straight through
      '{ROW_CSR,   MODE_SCORE,     6'd0,  16'h0000, 16'h0000, 1'b0, 32'h7FFF_FFFF, 1'b0},
      '{ROW_TYPED, MODE_SCORE,     6'd0,  16'h0000, 16'h0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{ROW_CSR,   MODE_SCORE,     6'd0,  16'h0000, 16'h0000, 1'b0, 32'h8000_0000, 1'b0},
      '{ROW_TYPED, MODE_SCORE,     6'd0,  16'h0000, 16'h0000, 1'b1, 32'h8000_0000, 1'b0},
      // a nonzero half sum at the negative rail clips
      '{ROW_TYPED, MODE_SCORE,     6'd0,  16'hFFC0, 16'h0000, 1'b1, 32'h8000_0000, 1'b1},
      // two-element vector; the index field of a score beat is don't-care
      '{ROW_BEAT,  MODE_LOAD_MEAN, 6'd1,  16'h7FFF, 16'h0000, 1'b0, 32'h0,        1'b0},
      '{ROW_BEAT,  MODE_LOAD_IVAR, 6'd1,  16'h0000, 16'hFFFF, 1'b0, 32'h0,        1'b0},
      '{ROW_BEAT,  MODE_SCORE,     6'd37, 16'h0000, 16'h1234, 1'b0, 32'h0,        1'b0},
      '{ROW_BEAT,  MODE_SCORE,     6'd5,  16'h8000, 16'hABCD, 1'b1, 32'h0,        1'b0}
   };

   // ---------------------------------------------------------------- DUT I/O
   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode          = '0;
   logic [5:0]         req_element_index = '0;
   logic signed [15:0] req_sample        = '0;
   logic [15:0]        req_inv_variance  = '0;
   logic               req_last          = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic signed [31:0] rsp_score;
   logic               rsp_saturated;
   logic               csr_wr_en         = 1'b0;
   logic signed [31:0] csr_wr_data       = '0;

   diagonal_gaussian_log_score dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_element_index (req_element_index),
      .req_sample        (req_sample),
      .req_inv_variance  (req_inv_variance),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_score         (rsp_score),
      .rsp_saturated     (rsp_saturated),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------ predictor state
   logic [15:0]        mean_mirror [MAX_DIM];
   logic [15:0]        ivar_mirror [MAX_DIM];
   logic [55:0]        distance_acc = '0;
   logic [5:0]         element_pos  = '0;
   logic signed [31:0] log_const    = '0;

   score_type expected_scores [$];

   // Knobs shared between the stimulus thread and the receiver
   bit gaps_on      = 1'b1;
   bit stall_on     = 1'b1;
   bit hold_request = 1'b0;

   int beats_sent   = 0;   // unused-mode beats not counted
   int results_seen = 0;
   int sat_expected = 0;
   int csr_writes   = 0;
   int mismatches   = 0;

   task automatic note_mismatch(input string what);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   // Advance the mirrored block state by one accepted beat. emits is set when
   // the beat closes a vector; res then holds the score it must produce.
   function automatic void predict_beat(input logic [1:0] mode, input logic [5:0] idx,
                                        input logic [15:0] smp, input logic [15:0] ivr,
                                        input logic is_last, output logic emits,
                                        output score_type res);
      logic [16:0] diff;
      logic [16:0] mag;
      logic [47:0] term;
      logic [56:0] half;
      longint      raw;
      emits     = 1'b0;
      res.score = '0;
      res.sat   = 1'b0;
      case (mode)
         MODE_LOAD_MEAN: begin
            if (idx < MAX_DIM) mean_mirror[idx] = smp;
         end
         MODE_LOAD_IVAR: begin
            if (idx < MAX_DIM) ivar_mirror[idx] = ivr;
         end
         MODE_SCORE: begin
            // 17-bit exact difference, squared and weighted exactly in 48 bits
            diff = {smp[15], smp} - {mean_mirror[element_pos][15], mean_mirror[element_pos]};
            mag  = diff[16] ? -diff : diff;
            term = 48'(mag) * 48'(mag) * 48'(ivar_mirror[element_pos]);
            if (distance_acc > SUM_MAX - 56'(term)) distance_acc = SUM_MAX;
            else distance_acc = distance_acc + 56'(term);
            element_pos = 6'((int'(element_pos) + 1) % MAX_DIM);
            if (is_last) begin
               // Q28.28 sum to Q16.16 half sum, ties round up
               half = (57'(distance_acc) + 57'd4096) >> 13;
               raw  = longint'(log_const) - longint'(half);
               res.sat = 1'b1;
               if (raw < SCORE_MIN) raw = SCORE_MIN;
               else if (raw > SCORE_MAX) raw = SCORE_MAX;
               else res.sat = 1'b0;
               res.score    = 32'(raw);
               emits        = 1'b1;
               distance_acc = '0;
               element_pos  = '0;
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------- input side
   // Offer one beat (after an optional gap) and hold it until accepted.
   task automatic send_beat(input logic [1:0] mode, input logic [5:0] idx,
                            input logic [15:0] smp, input logic [15:0] ivr,
                            input logic is_last, input bit typed = 1'b0,
                            input logic [31:0] typed_score = '0,
                            input logic typed_sat = 1'b0);
      logic      emits;
      score_type res;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_element_index <= idx;
      req_sample        <= smp;
      req_inv_variance  <= ivr;
      req_last          <= is_last;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_beat(mode, idx, smp, ivr, is_last, emits, res);
      if (emits) begin
         if (typed) begin
            res.score = typed_score;
            res.sat   = typed_sat;
         end
         expected_scores.push_back(res);
         if (res.sat) sat_expected++;
      end
      if (mode != MODE_UNUSED) beats_sent++;
   endtask

   // Lower valid and wait until every expected result is back, plus the
   // in-flight time of a score beat that had no last flag.
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [31:0] value);
      drain_pipeline();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      log_const = value;
      csr_writes++;
   endtask

   // Mostly small weights so scores stay in range; now and then full scale.
   function automatic logic [15:0] scaled_ivar();
      logic [15:0] raw;
      raw = 16'($urandom);
      if ($urandom_range(0, 7) == 0) return raw;
      return raw >> $urandom_range(2, 15);
   endfunction

   // Sample near the mean it will meet, or anywhere in range
   function automatic logic [15:0] pick_sample();
      int span;
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      span = 1 << $urandom_range(0, 9);
      return mean_mirror[element_pos] + 16'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic int vector_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(1, 8);
      if (r < 18) return $urandom_range(9, 40);
      return $urandom_range(60, 130);   // wraps the element counter
   endfunction

   task automatic fill_stores(input bit extreme);
      for (int i = 0; i < MAX_DIM; i++) begin
         send_beat(MODE_LOAD_MEAN, 6'(i), extreme ? 16'h8000 : 16'($urandom),
                   16'($urandom), 1'($urandom));
         send_beat(MODE_LOAD_IVAR, 6'(i), 16'($urandom),
                   extreme ? 16'hFFFF : scaled_ivar(), 1'($urandom));
      end
   endtask

   // A load into a random entry or an unused-mode beat; every entry has
   // already been written, so later reads stay defined.
   task automatic send_stray();
      case ($urandom_range(0, 2))
         0: send_beat(MODE_LOAD_MEAN, 6'($urandom), 16'($urandom), 16'($urandom),
                      1'($urandom));
         1: send_beat(MODE_LOAD_IVAR, 6'($urandom), 16'($urandom), scaled_ivar(),
                      1'($urandom));
         default: send_beat(MODE_UNUSED, 6'($urandom), 16'($urandom), 16'($urandom),
                            1'($urandom));
      endcase
   endtask

   task automatic send_vector(input int len);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 11) == 0) send_stray();
         send_beat(MODE_SCORE, 6'($urandom), pick_sample(), 16'($urandom), k == len - 1);
      end
   endtask

   // --------------------------------------------------------- result side
   // Random stall bursts, plus one long hold-off on request.
   int hold_left  = 0;
   int stall_left = 0;

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every result beat is matched against the oldest expected score.
   always @(posedge clock) begin : check_results
      score_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         results_seen++;
         if (expected_scores.size() == 0) begin
            note_mismatch($sformatf("result beat with none expected (score %h)", rsp_score));
         end else begin
            want = expected_scores.pop_front();
            if (rsp_score !== want.score)
               note_mismatch($sformatf("score got %h want %h", rsp_score, want.score));
            if (rsp_saturated !== want.sat)
               note_mismatch($sformatf("saturated got %b want %b", rsp_saturated, want.sat));
         end
      end
   end

   // ------------------------------------------------------------ stimulus
   initial begin : stimulus
      logic signed [31:0] lc_plan [PHASES];
      int                 phase_end;
      lc_plan[0] = 32'($urandom);
      lc_plan[1] = 32'sh7FFF_FFFF;
      lc_plan[2] = 32'sh8000_0000;
      lc_plan[3] = 32'sh0;
      lc_plan[4] = 32'($urandom_range(0, 1 << 23)) - 32'sd4194304;
      lc_plan[5] = 32'($urandom);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table; only entries 0, 1 and 63 are touched here
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (DIRECTED[i].kind == ROW_CSR) csr_write(DIRECTED[i].value);
         else send_beat(DIRECTED[i].mode, DIRECTED[i].idx, DIRECTED[i].smp,
                        DIRECTED[i].ivr, DIRECTED[i].is_last,
                        DIRECTED[i].kind == ROW_TYPED, DIRECTED[i].value,
                        DIRECTED[i].sat);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         // last phase runs flat out on both sides; set ahead of the drain
         gaps_on  = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
         stall_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
         csr_write(lc_plan[ph]);
         @(posedge clock);
         case (ph)
            PH_PRELOAD: begin
               fill_stores(1'b0);   // every entry defined before random reads
            end
            PH_BACKPRESSURE: begin
               // receiver goes dark while one-element vectors keep coming
               hold_request = 1'b1;
               repeat (30) send_vector(1);
            end
            PH_OVERFLOW: begin
               // 300 full-scale terms push the accumulator to its ceiling
               fill_stores(1'b1);
               for (int k = 0; k < 300; k++)
                  send_beat(MODE_SCORE, 6'($urandom), 16'h7FFF, 16'($urandom), k == 299);
               fill_stores(1'b0);
            end
            PH_DRAIN: begin
               repeat (10) send_vector(vector_length());
               drain_pipeline();
            end
            default: ;
         endcase
         phase_end = beats_sent + (ITEMS_TARGET - beats_sent) / (PHASES - ph);
         while (beats_sent < phase_end) begin
            if ($urandom_range(0, 4) != 0) send_vector(vector_length());
            else send_stray();
         end
      end

      drain_pipeline();
      $display("Covered %0d beats: %0d directed rows, %0d vectors scored, %0d clipped.",
               beats_sent, N_DIRECTED, results_seen, sat_expected);
      $display("Register written %0d times incl. both rails; stalls, long hold-off, overflow.",
               csr_writes);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #(TIMEOUT_UNITS);
      $display("Timeout, %0d results still outstanding", expected_scores.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
